// ===== design/sens_pkg.sv =====
// Package for the stereo excitation noise shaper: widths, constants, opcodes, types.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package sens_pkg;
    localparam int DefChannels     = 2;
    localparam int DefInternalBits = 32;
    localparam int NoiseW = 18;
    localparam int OutW   = 24;
    localparam int CfgW   = 19;
    localparam int CfgIdxW = 3;

    // Q.24 constants
    localparam logic signed [27:0] KPinkPoleA   = 28'sd16737790;
    localparam logic signed [27:0] KPinkPoleB   = 28'sd16156459;
    localparam logic signed [27:0] KPinkPoleC   = 28'sd9563013;
    localparam logic signed [27:0] KPinkGainA   = 28'sd1661716;
    localparam logic signed [27:0] KPinkGainB   = 28'sd4974720;
    localparam logic signed [27:0] KPinkGainC   = 28'sd17661229;
    localparam logic signed [27:0] KPinkDirect  = 28'sd3100430;
    localparam logic signed [27:0] KMalletMakeup = 28'sd53687091;
    localparam logic signed [27:0] KDiffMakeup  = 28'sd11744051;

    typedef enum logic [2:0] {
        REG_SOURCE_MODE = 3'd0, REG_MALLET_COEF = 3'd1, REG_COLOUR_COEF = 3'd2,
        REG_COLOUR_WEIGHT = 3'd3, REG_TILT_GAIN = 3'd4, REG_BRIGHT_COEF = 3'd5,
        REG_BRIGHT_GAIN = 3'd6, REG_DC_COEF = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_WHITE = 2'd0, MODE_PINK = 2'd1, MODE_MALLET = 2'd2, MODE_DIFF = 2'd3
    } t_mode;

    // one datapath operation per step
    typedef enum logic [3:0] {
        OP_LOAD, OP_PINK_A, OP_PINK_B, OP_PINK_C, OP_PINK_D, OP_PINK_SUM,
        OP_MALLET, OP_MALLET_MK, OP_DIFF, OP_COLOUR, OP_TILT, OP_TILT_GAIN,
        OP_BRIGHT, OP_BRIGHT_GAIN, OP_DC, OP_OUT
    } t_op;

    typedef struct packed {
        logic  valid;
        t_op   op;
        logic  ch;
    } t_cmd;
endpackage

// ===== design/sens_ctrl.sv =====
// Sequencer for the noise shaper: walks each channel through the datapath operations.
// Depends on sens_pkg.
`timescale 1ns / 1ps
module sens_ctrl
    import sens_pkg::*;
#(
    parameter int CHANNELS = DefChannels
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_mode i_mode,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_SRC = 4'b0010, S_SHAPE = 4'b0100, S_DONE = 4'b1000
    } t_state;

    localparam int LastCh = (CHANNELS > 2 ? 2 : CHANNELS) - 1;

    t_state r_state, n_state;
    logic [2:0] r_step, n_step;
    logic r_ch, n_ch;
    t_op  w_op;
    logic w_last;

    // pick the op for this step
    always_comb begin
        w_op = OP_LOAD;
        w_last = 1'b0;
        if (r_state == S_SRC) begin
            case (i_mode)
                MODE_PINK: begin
                    case (r_step)
                        3'd0: w_op = OP_LOAD;
                        3'd1: w_op = OP_PINK_A;
                        3'd2: w_op = OP_PINK_B;
                        3'd3: w_op = OP_PINK_C;
                        3'd4: w_op = OP_PINK_D;
                        default: begin w_op = OP_PINK_SUM; w_last = 1'b1; end
                    endcase
                end
                MODE_MALLET: begin
                    case (r_step)
                        3'd0: w_op = OP_LOAD;
                        3'd1: w_op = OP_MALLET;
                        default: begin w_op = OP_MALLET_MK; w_last = 1'b1; end
                    endcase
                end
                MODE_DIFF: begin
                    if (r_step == 3'd0) w_op = OP_LOAD;
                    else begin w_op = OP_DIFF; w_last = 1'b1; end
                end
                default: begin w_op = OP_LOAD; w_last = 1'b1; end
            endcase
        end else if (r_state == S_SHAPE) begin
            case (r_step)
                3'd0: w_op = OP_COLOUR;
                3'd1: w_op = OP_TILT;
                3'd2: w_op = OP_TILT_GAIN;
                3'd3: w_op = OP_BRIGHT;
                3'd4: w_op = OP_BRIGHT_GAIN;
                3'd5: w_op = OP_DC;
                default: begin w_op = OP_OUT; w_last = 1'b1; end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_ch    = r_ch;
        case (r_state)
            S_IDLE: begin
                n_step = 3'd0;
                n_ch   = 1'b0;
                if (i_start) n_state = S_SRC;
            end
            S_SRC: begin
                if (w_last) begin n_state = S_SHAPE; n_step = 3'd0; end
                else n_step = r_step + 3'd1;
            end
            S_SHAPE: begin
                if (w_last) begin
                    n_step = 3'd0;
                    if (r_ch == LastCh[0]) n_state = S_DONE;
                    else begin n_ch = 1'b1; n_state = S_SRC; end
                end else n_step = r_step + 3'd1;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 3'd0;
            r_ch    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ch    <= n_ch;
        end
    end

    assign o_cmd.valid = (r_state == S_SRC) || (r_state == S_SHAPE);
    assign o_cmd.op    = w_op;
    assign o_cmd.ch    = r_ch;
    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);
endmodule

// ===== design/sens_dp.sv =====
// Datapath for the noise shaper: filter state per channel, one multiply-round per op.
// Depends on sens_pkg.
`timescale 1ns / 1ps
module sens_dp
    import sens_pkg::*;
#(
    parameter int CHANNELS      = DefChannels,
    parameter int INTERNAL_BITS = DefInternalBits
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic                     i_load,
    input  logic signed [NoiseW-1:0] i_noise_l,
    input  logic signed [NoiseW-1:0] i_noise_r,
    input  logic [17:0]              i_gain,
    input  logic [17:0]              i_mallet_coef,
    input  logic [17:0]              i_colour_coef,
    input  logic signed [CfgW-1:0]   i_colour_weight,
    input  logic [17:0]              i_tilt_gain,
    input  logic [17:0]              i_bright_coef,
    input  logic [17:0]              i_bright_gain,
    input  logic [17:0]              i_dc_coef,
    output logic signed [OutW-1:0]   o_out_l,
    output logic signed [OutW-1:0]   o_out_r
);
    localparam int IB = INTERNAL_BITS;
    localparam int AW = IB + 34;   // product width with headroom
    localparam int NS = (CHANNELS > 2) ? 2 : CHANNELS;

    typedef logic signed [IB-1:0] t_sig;
    typedef logic signed [AW-1:0] t_acc;

    t_sig r_pa [NS], r_pb [NS], r_pc [NS], r_ml [NS], r_cl [NS];
    t_sig r_bl [NS], r_dpi [NS], r_dpo [NS];
    logic signed [NoiseW-1:0] r_dprev [NS];

    logic signed [NoiseW-1:0] r_raw_l, r_raw_r;
    logic [17:0] r_gain;
    t_sig r_x, r_s, r_low, r_t, r_f;
    t_acc r_sum;
    logic signed [OutW-1:0] r_out_l, r_out_r;

    function automatic t_acc rsh(input t_acc v, input int s);
        t_acc h;
        h = t_acc'(1) <<< (s - 1);
        return (v + h) >>> s;
    endfunction

    function automatic t_sig sat(input t_acc v);
        t_acc hi, lo;
        hi = (t_acc'(1) <<< (IB - 1)) - t_acc'(1);
        lo = -hi - t_acc'(1);
        if (v > hi) return hi[IB-1:0];
        if (v < lo) return lo[IB-1:0];
        return v[IB-1:0];
    endfunction

    function automatic t_acc ext(input t_sig v);
        return t_acc'(v);
    endfunction

    function automatic t_acc onepole(input t_sig lp, input logic [17:0] c, input t_sig x);
        t_acc cs, cm;
        cs = t_acc'({1'b0, c});
        cm = t_acc'(262144) - cs;
        return cs * ext(lp) + cm * ext(x);
    endfunction

    logic ch;
    t_acc w_x;
    t_acc w_p;
    assign ch  = (NS > 1) ? i_cmd.ch : 1'b0;
    assign w_x = ext(r_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NS; c++) begin
                r_pa[c] <= '0; r_pb[c] <= '0; r_pc[c] <= '0; r_ml[c] <= '0;
                r_cl[c] <= '0; r_bl[c] <= '0; r_dpi[c] <= '0; r_dpo[c] <= '0;
                r_dprev[c] <= '0;
            end
            r_out_l <= '0;
            r_out_r <= '0;
        end else if (i_cmd.valid) begin
            case (i_cmd.op)
                OP_LOAD: begin
                    // x = raw * 16, white passes straight to shaping
                    r_x <= t_sig'((ch ? r_raw_r : r_raw_l)) <<< 4;
                    r_s <= t_sig'((ch ? r_raw_r : r_raw_l)) <<< 4;
                end
                OP_PINK_A: r_pa[ch] <= sat(rsh(t_acc'(KPinkPoleA) * ext(r_pa[ch])
                                      + t_acc'(KPinkGainA) * w_x, 24));
                OP_PINK_B: r_pb[ch] <= sat(rsh(t_acc'(KPinkPoleB) * ext(r_pb[ch])
                                      + t_acc'(KPinkGainB) * w_x, 24));
                OP_PINK_C: r_pc[ch] <= sat(rsh(t_acc'(KPinkPoleC) * ext(r_pc[ch])
                                      + t_acc'(KPinkGainC) * w_x, 24));
                OP_PINK_D: r_sum <= ext(r_pa[ch]) + ext(r_pb[ch]) + ext(r_pc[ch])
                                    + rsh(t_acc'(KPinkDirect) * w_x, 24);
                OP_PINK_SUM: r_s <= sat(rsh(r_sum, 2));
                OP_MALLET: r_ml[ch] <= sat(rsh(onepole(r_ml[ch], i_mallet_coef, r_x), 18));
                OP_MALLET_MK: r_s <= sat(rsh(t_acc'(KMalletMakeup) * ext(r_ml[ch]), 24));
                OP_DIFF: begin
                    r_s <= sat(rsh(t_acc'(KDiffMakeup)
                           * (w_x - (t_acc'(r_dprev[ch]) <<< 4)), 24));
                    r_dprev[ch] <= ch ? r_raw_r : r_raw_l;
                end
                OP_COLOUR: begin
                    r_cl[ch]  <= sat(rsh(onepole(r_cl[ch], i_colour_coef, r_s), 18));
                    r_low     <= sat(rsh(onepole(r_cl[ch], i_colour_coef, r_s), 18));
                end
                OP_TILT: r_sum <= rsh((ext(r_s) <<< 17) + t_acc'(i_colour_weight)
                                  * (ext(r_s) - (ext(r_low) <<< 1)), 17);
                OP_TILT_GAIN: r_t <= sat(rsh(r_sum * t_acc'({1'b0, i_tilt_gain}), 17));
                OP_BRIGHT: r_bl[ch] <= sat(rsh(onepole(r_bl[ch], i_bright_coef, r_t), 18));
                OP_BRIGHT_GAIN: r_f <= sat(rsh(ext(r_bl[ch])
                                       * t_acc'({1'b0, i_bright_gain}), 15));
                OP_DC: begin
                    r_dpo[ch] <= sat(ext(r_f) - ext(r_dpi[ch])
                                 + rsh(t_acc'({1'b0, i_dc_coef}) * ext(r_dpo[ch]), 18));
                    r_dpi[ch] <= r_f;
                end
                OP_OUT: begin
                    if (ch) r_out_r <= w_p[OutW-1:0];
                    else    r_out_l <= w_p[OutW-1:0];
                end
                default: ;
            endcase
        end
    end

    // final gain and 24-bit saturation
    always_comb begin
        t_acc v;
        v = rsh(ext(r_dpo[ch]) * t_acc'({1'b0, r_gain}), 17);
        if (v > t_acc'(8388607)) w_p = t_acc'(8388607);
        else if (v < -t_acc'(8388608)) w_p = -t_acc'(8388608);
        else w_p = v;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_raw_l <= i_noise_l;
            r_raw_r <= i_noise_r;
            r_gain  <= i_gain;
        end
    end

    assign o_out_l = r_out_l;
    assign o_out_r = (NS > 1) ? r_out_r : '0;
endmodule

// ===== design/stereo_excitation_noise_shaper_top.sv =====
// Top level of the stereo excitation noise shaper: streams, config registers, assembly.
// Depends on sens_pkg, sens_ctrl and sens_dp.
`timescale 1ns / 1ps
//  channel   direction  tdata fields (low bit up)
//  s_axis    in         noise_left[17:0], noise_right[35:18], gain[53:36], pad to 56
//  m_axis    out        out_left[23:0], out_right[47:24]
//  cfg       in         i_cfg_we, i_cfg_idx, i_cfg_data[18:0]
// An item takes 8 to 13 controller steps per channel, set by the single shared
// multiply-round step of the datapath sequencer.
// The result sits in an output register; a new item is taken once the sequence
// ends and that register is empty or is being taken by m_axis_tready.
// Reset is synchronous, active low, clears filter state and sets config registers to their defaults.
module stereo_excitation_noise_shaper_top
    import sens_pkg::*;
#(
    parameter int CHANNELS      = DefChannels,
    parameter int INTERNAL_BITS = DefInternalBits
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [55:0]         s_axis_tdata,   // noise_left, noise_right, gain
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [47:0]         m_axis_tdata,   // out_left, out_right
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgW-1:0]     i_cfg_data
);
    logic [1:0]  r_mode;
    logic [17:0] r_mallet, r_colour, r_tilt, r_bcoef, r_bgain, r_dc;
    logic signed [CfgW-1:0] r_weight;

    // config writes, any index in the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0; r_mallet <= '0; r_colour <= '0; r_weight <= '0;
            r_tilt <= 18'd131072; r_bcoef <= '0; r_bgain <= 18'd32768; r_dc <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SOURCE_MODE:   r_mode   <= i_cfg_data[1:0];
                REG_MALLET_COEF:   r_mallet <= i_cfg_data[17:0];
                REG_COLOUR_COEF:   r_colour <= i_cfg_data[17:0];
                REG_COLOUR_WEIGHT: r_weight <= i_cfg_data;
                REG_TILT_GAIN:     r_tilt   <= i_cfg_data[17:0];
                REG_BRIGHT_COEF:   r_bcoef  <= i_cfg_data[17:0];
                REG_BRIGHT_GAIN:   r_bgain  <= i_cfg_data[17:0];
                REG_DC_COEF:       r_dc     <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    t_cmd w_cmd;
    logic w_busy, w_done, w_start;
    logic signed [OutW-1:0] w_out_l, w_out_r;
    logic r_ovalid;

    // accept a transfer when the sequencer is free and the output register drains
    assign s_axis_tready = !w_busy && (!r_ovalid || m_axis_tready);
    assign w_start = s_axis_tvalid && s_axis_tready;

    sens_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_mode(t_mode'(r_mode)), .o_cmd(w_cmd), .o_busy(w_busy), .o_done(w_done)
    );

    sens_dp #(.CHANNELS(CHANNELS), .INTERNAL_BITS(INTERNAL_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_load(w_start),
        .i_noise_l(s_axis_tdata[17:0]), .i_noise_r(s_axis_tdata[35:18]),
        .i_gain(s_axis_tdata[53:36]),
        .i_mallet_coef(r_mallet), .i_colour_coef(r_colour), .i_colour_weight(r_weight),
        .i_tilt_gain(r_tilt), .i_bright_coef(r_bcoef), .i_bright_gain(r_bgain),
        .i_dc_coef(r_dc), .o_out_l(w_out_l), .o_out_r(w_out_r)
    );

    // hold the result until the downstream side takes it
    logic [47:0] r_odata;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_done) r_odata <= {w_out_r, w_out_l};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // a finished item never overwrites an untaken result: a start needs the output register free
    a_done_not_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_busy) else $error("sequencer did not start");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready) else $error("accept while busy");
    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> m_axis_tvalid) else $error("result lost");
endmodule
